/* design/tmh_pkg.sv */
// shared types, constants and helper functions for the timer min-heap
// no dependencies; imported by every module of the block but tmh_ram
package tmh_pkg;

	localparam int CAPACITY = 32;
	localparam int ID_SPACE = 1024;
	localparam int ID_W     = $clog2(ID_SPACE);
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int EXP_W    = 32;
	localparam int TMO_W    = 24;
	localparam int REQ_W    = 3;
	localparam int ST_W     = 2;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 48;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD  = 3'd0,
		REQ_ADJ  = 3'd1,
		REQ_FIRE = 3'd2,
		REQ_EXP  = 3'd3,
		REQ_POP  = 3'd4,
		REQ_CLR  = 3'd5
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_UNK   = 2'd2,
		ST_EMPTY = 2'd3
	} st_t;

	typedef enum logic [2:0] {
		RD_SLOT, RD_LAST, RD_ROOT, RD_CHILD, RD_CHILD1, RD_PARENT
	} rd_sel_t;

	typedef struct packed {
		logic [ID_W-1:0]  own;
		logic [EXP_W-1:0] exp;
	} heap_ent_t;

	typedef struct packed {
		logic    accept;
		logic    map_rd;
		logic    rd;
		rd_sel_t rd_sel;
		logic    set_st;
		st_t     st;
		logic    add_start;
		logic    adj_start;
		logic    rm_start;
		logic    rm_slot;
		logic    who_hr;
		logic    who_id;
		logic    rm_dec;
		logic    load_cur_hr;
		logic    load_ch;
		logic    load_ch_b;
		logic    move_ch;
		logic    move_par;
		logic    place;
		logic    clear;
		logic    emit;
		logic    emit_fired;
		logic    emit_last;
	} dp_cmd_t;

	typedef struct packed {
		req_t req;
		logic cnt_zero;
		logic full;
		logic found;
		logic idx_zero;
		logic idx_last;
		logic c_ok;
		logic c1_ok;
		logic b_better;
		logic cur_later_ch;
		logic par_later;
		logic root_due;
		logic up_after;
		logic moved;
		logic out_free;
	} dp_sts_t;

	// wrap-aware: a later than b when (a - b) mod 2^32 lies in 1 .. 2^31-1
	function automatic logic later(input logic [EXP_W-1:0] a, input logic [EXP_W-1:0] b);
		logic [EXP_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[EXP_W-1];
	endfunction

	function automatic logic [TMO_W-1:0] tick_of(input logic [EXP_W-1:0] e,
			input logic [EXP_W-1:0] now);
		logic [EXP_W-1:0] d;
		d = e - now;
		if (d == '0 || d[EXP_W-1])
			return '0;
		else if (|d[EXP_W-1:TMO_W])
			return '1;
		else
			return d[TMO_W-1:0];
	endfunction

endpackage

/* design/tmh_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module tmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* design/tmh_dp.sv */
// datapath: request registers, heap and id-map memories, sift registers, result register
// depends on tmh_pkg and tmh_ram
module tmh_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tmh_pkg::dp_cmd_t        cmd,
	output tmh_pkg::dp_sts_t        sts,
	input  logic [tmh_pkg::IN_W-1:0] s_tdata,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [tmh_pkg::OUT_W-1:0] m_tdata,
	output logic                    m_tuser,
	output logic                    m_tlast
);
	import tmh_pkg::*;

	req_t             req_q;
	logic [ID_W-1:0]  id_q;
	logic [EXP_W-1:0] now_q;
	logic [EXP_W-1:0] exp_new_q;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] csel_q;
	heap_ent_t        cur_q;
	heap_ent_t        ch_q;
	logic [ID_W-1:0]  who_q;
	st_t              st_q;
	logic             moved_q;
	logic             up_after_q;

	logic             out_valid_q;
	logic             out_fired_q;
	logic [ID_W-1:0]  out_id_q;
	logic [TMO_W-1:0] out_tick_q;
	logic [CNT_W-1:0] out_occ_q;
	st_t              out_st_q;
	logic             out_last_q;

	heap_ent_t         hr;
	logic [$bits(heap_ent_t)-1:0] hr_raw;
	logic [SLOT_W-1:0] mr;
	logic [SLOT_W-1:0] h_raddr;
	logic              h_we;
	heap_ent_t         h_wdata;
	logic [SLOT_W:0]   cidx;
	logic [SLOT_W+1:0] cidx1;
	logic [SLOT_W-1:0] parent;
	logic [CNT_W-1:0]  count_m1;

	assign hr       = heap_ent_t'(hr_raw);
	assign cidx     = {idx_q, 1'b1};
	assign cidx1    = {1'b0, cidx} + (SLOT_W+2)'(1);
	assign parent   = SLOT_W'((idx_q - SLOT_W'(1)) >> 1);
	assign count_m1 = count_q - CNT_W'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_SLOT:   h_raddr = mr;
			RD_LAST:   h_raddr = count_m1[SLOT_W-1:0];
			RD_ROOT:   h_raddr = '0;
			RD_CHILD:  h_raddr = cidx[SLOT_W-1:0];
			RD_CHILD1: h_raddr = cidx1[SLOT_W-1:0];
			RD_PARENT: h_raddr = parent;
			default:   h_raddr = '0;
		endcase
	end

	assign h_we = cmd.move_ch | cmd.move_par | cmd.place;

	always_comb begin
		if (cmd.move_ch)
			h_wdata = ch_q;
		else if (cmd.move_par)
			h_wdata = hr;
		else
			h_wdata = cur_q;
	end

	tmh_ram #(.WIDTH($bits(heap_ent_t)), .DEPTH(CAPACITY)) u_heap (
		.clk   (clk),
		.we    (h_we),
		.waddr (idx_q),
		.wdata (h_wdata),
		.re    (cmd.rd),
		.raddr (h_raddr),
		.rdata (hr_raw)
	);

	// slot of each id; only trusted when the slot it names is in use and holds that id
	tmh_ram #(.WIDTH(SLOT_W), .DEPTH(ID_SPACE)) u_map (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_wdata.own),
		.wdata (idx_q),
		.re    (cmd.map_rd),
		.raddr (id_q),
		.rdata (mr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear)
				count_q <= '0;
			else if (cmd.add_start)
				count_q <= count_q + CNT_W'(1);
			else if (cmd.rm_dec)
				count_q <= count_m1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= req_t'(s_tdata[REQ_W-1:0]);
			id_q      <= s_tdata[REQ_W +: ID_W];
			now_q     <= s_tdata[REQ_W+ID_W+TMO_W +: EXP_W];
			exp_new_q <= s_tdata[REQ_W+ID_W+TMO_W +: EXP_W]
				+ EXP_W'(s_tdata[REQ_W+ID_W +: TMO_W]);
		end
		if (cmd.accept)
			st_q <= ST_OK;
		else if (cmd.set_st)
			st_q <= cmd.st;
		if (cmd.add_start) begin
			cur_q <= '{own: id_q, exp: exp_new_q};
			idx_q <= count_q[SLOT_W-1:0];
		end else if (cmd.adj_start) begin
			cur_q      <= '{own: id_q, exp: exp_new_q};
			idx_q      <= mr;
			up_after_q <= 1'b0;
			moved_q    <= 1'b0;
		end else if (cmd.rm_start) begin
			idx_q <= cmd.rm_slot ? mr : '0;
		end else if (cmd.load_cur_hr) begin
			cur_q      <= hr;
			up_after_q <= 1'b1;
			moved_q    <= 1'b0;
		end else if (cmd.move_ch) begin
			idx_q   <= csel_q;
			moved_q <= 1'b1;
		end else if (cmd.move_par) begin
			idx_q <= parent;
		end
		if (cmd.load_ch) begin
			ch_q   <= hr;
			csel_q <= cidx[SLOT_W-1:0];
		end else if (cmd.load_ch_b) begin
			ch_q   <= hr;
			csel_q <= cidx1[SLOT_W-1:0];
		end
		if (cmd.who_hr)
			who_q <= hr.own;
		else if (cmd.who_id)
			who_q <= id_q;
		if (cmd.emit) begin
			out_fired_q <= cmd.emit_fired;
			out_id_q    <= cmd.emit_fired ? who_q : '0;
			out_tick_q  <= (cmd.emit_fired || count_q == '0) ? '0 : tick_of(hr.exp, now_q);
			out_occ_q   <= count_q;
			out_st_q    <= cmd.emit_fired ? ST_OK : st_q;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign sts.req          = req_q;
	assign sts.cnt_zero     = (count_q == '0);
	assign sts.full         = (count_q >= CNT_W'(CAPACITY));
	assign sts.found        = (CNT_W'(mr) < count_q) && (hr.own == id_q);
	assign sts.idx_zero     = (idx_q == '0);
	assign sts.idx_last     = (CNT_W'(idx_q) == count_m1);
	assign sts.c_ok         = ((SLOT_W+2)'(cidx) < (SLOT_W+2)'(count_q));
	assign sts.c1_ok        = (cidx1 < (SLOT_W+2)'(count_q));
	assign sts.b_better     = later(ch_q.exp, hr.exp);
	assign sts.cur_later_ch = later(cur_q.exp, ch_q.exp);
	assign sts.par_later    = later(hr.exp, cur_q.exp);
	assign sts.root_due     = !later(hr.exp, now_q);
	assign sts.up_after     = up_after_q;
	assign sts.moved        = moved_q;
	assign sts.out_free     = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_W'({out_st_q, out_occ_q, out_tick_q, out_id_q});

endmodule

/* design/tmh_ctrl.sv */
// controller: sequences lookups, sifts, removals and result transactions
// depends on tmh_pkg; drives the datapath through dp_cmd_t
module tmh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  tmh_pkg::dp_sts_t sts,
	output tmh_pkg::dp_cmd_t cmd
);
	import tmh_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_LK1, S_LK2, S_RM0, S_RM1,
		S_DN0, S_DN1, S_DN2, S_DN3, S_DN_END, S_UP0, S_UP1,
		S_AFTER, S_EXP_RD, S_EXP_CHK, S_TICK0,
		S_EMIT_F, S_EMIT_X, S_EMIT_E
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.req)
					REQ_ADD, REQ_ADJ, REQ_FIRE: begin
						cmd.map_rd = 1'b1;
						state_d    = S_LK1;
					end
					REQ_EXP, REQ_POP: begin
						if (sts.cnt_zero) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_EMPTY;
							state_d    = S_TICK0;
						end else if (sts.req == REQ_EXP) begin
							state_d = S_EXP_RD;
						end else begin
							cmd.rm_start = 1'b1;
							state_d      = S_RM0;
						end
					end
					REQ_CLR: begin
						cmd.clear = 1'b1;
						state_d   = S_TICK0;
					end
					default: state_d = S_TICK0;
				endcase
			end
			S_LK1: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = RD_SLOT;
				state_d    = S_LK2;
			end
			S_LK2: begin
				// a map entry never written gives no match
				case (sts.req)
					REQ_ADD: begin
						if (sts.found || sts.full) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_DUP;
							state_d    = S_TICK0;
						end else begin
							cmd.add_start = 1'b1;
							state_d       = S_UP0;
						end
					end
					REQ_ADJ: begin
						if (sts.found) begin
							cmd.adj_start = 1'b1;
							state_d       = S_DN0;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_UNK;
							state_d    = S_TICK0;
						end
					end
					default: begin
						if (sts.found) begin
							cmd.rm_start = 1'b1;
							cmd.rm_slot  = 1'b1;
							cmd.who_id   = 1'b1;
							state_d      = S_RM0;
						end else begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_UNK;
							state_d    = S_TICK0;
						end
					end
				endcase
			end
			S_RM0: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = RD_LAST;
				cmd.rm_dec = 1'b1;
				state_d    = sts.idx_last ? S_AFTER : S_RM1;
			end
			S_RM1: begin
				cmd.load_cur_hr = 1'b1;
				state_d         = S_DN0;
			end
			S_DN0: begin
				if (sts.c_ok) begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = RD_CHILD;
					state_d    = S_DN1;
				end else begin
					state_d = S_DN_END;
				end
			end
			S_DN1: begin
				cmd.load_ch = 1'b1;
				if (sts.c1_ok) begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = RD_CHILD1;
					state_d    = S_DN2;
				end else begin
					state_d = S_DN3;
				end
			end
			S_DN2: begin
				cmd.load_ch_b = sts.b_better;
				state_d       = S_DN3;
			end
			S_DN3: begin
				if (sts.cur_later_ch) begin
					cmd.move_ch = 1'b1;
					state_d     = S_DN0;
				end else begin
					state_d = S_DN_END;
				end
			end
			S_DN_END: begin
				if (sts.up_after && !sts.moved) begin
					state_d = S_UP0;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_AFTER;
				end
			end
			S_UP0: begin
				if (sts.idx_zero) begin
					cmd.place = 1'b1;
					state_d   = S_AFTER;
				end else begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = RD_PARENT;
					state_d    = S_UP1;
				end
			end
			S_UP1: begin
				if (sts.par_later) begin
					cmd.move_par = 1'b1;
					state_d      = S_UP0;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_AFTER;
				end
			end
			S_AFTER: begin
				case (sts.req)
					REQ_EXP:  state_d = S_EMIT_E;
					REQ_FIRE: state_d = S_EMIT_X;
					default:  state_d = S_TICK0;
				endcase
			end
			S_EXP_RD: begin
				if (sts.cnt_zero) begin
					state_d = S_TICK0;
				end else begin
					cmd.rd     = 1'b1;
					cmd.rd_sel = RD_ROOT;
					state_d    = S_EXP_CHK;
				end
			end
			S_EXP_CHK: begin
				if (sts.root_due) begin
					cmd.rm_start = 1'b1;
					cmd.who_hr   = 1'b1;
					state_d      = S_RM0;
				end else begin
					state_d = S_EMIT_F;
				end
			end
			S_TICK0: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = RD_ROOT;
				state_d    = S_EMIT_F;
			end
			S_EMIT_F: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_EMIT_X: begin
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_fired = 1'b1;
					cmd.emit_last  = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_EMIT_E: begin
				if (sts.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_fired = 1'b1;
					state_d        = S_EXP_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* design/timer_min_heap.sv */
// timer store kept as an indexed binary min-heap ordered by expiry
// top level; depends on tmh_pkg, tmh_ctrl, tmh_dp (and tmh_ram below it)
//
// usage
//  - one request transaction on the s_ channel carries type, timer id, timeout and
//    the current time; requests are add, adjust, fire by id, expire due, pop, clear
//  - each request gives one or more result transactions on the m_ channel; m_tlast
//    marks the final one, m_tuser flags a result that reports a fired timer
//  - s_tready is high only while no request is in progress; a new request may be
//    taken while the last result still sits in the output register
//  - order of work: dispatch and, for requests that name an id, the id lookup, then a
//    sift of one level at a time, up or down (heap memory read port, one entry a
//    cycle), then the earliest-expiry read and result; clear, empty pop or expire
//    and unknown type skip the sift; expire repeats the removal per due timer
//  - the single read port of the heap memory sets the rate; sifts never overlap
//  - reset clears the timer count and the controller; the heap and id map need no
//    clearing pass since an id is present only when its mapped slot holds that id
//  - when the receiver stalls, the result is held and the controller waits before
//    loading the next one; no result is dropped or repeated
module timer_min_heap (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// req_type[2:0], timer_id[12:3], timeout_ms[36:13], now_ms[68:37], zero fill
	input  logic [tmh_pkg::IN_W-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// fired_id[9:0], next_tick_ms[33:10], occupancy[39:34], status[41:40], zero fill
	output logic [tmh_pkg::OUT_W-1:0] m_tdata,
	// fired[0]
	output logic                     m_tuser,
	output logic                     m_tlast
);
	import tmh_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// request sequencing
	tmh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// heap storage, comparisons and result register
	tmh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* design/tmh_chk.sv */
// port-level checker for timer_min_heap, attached by bind
// depends on tmh_pkg
module tmh_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [tmh_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tmh_pkg::OUT_W-1:0] m_tdata,
	input logic                      m_tuser,
	input logic                      m_tlast
);
	import tmh_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a taken request leaves s_tready low in the following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// occupancy never exceeds the capacity
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	// a non-firing result always closes the request
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("non-firing result not last");

	// a firing result carries no tick and an ok status
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[33:10] == '0 && m_tdata[41:40] == ST_OK)
		else $error("firing result with tick or status");

endmodule

bind timer_min_heap tmh_chk u_chk (.*);

/* tb/tb_timer_min_heap.sv */
// self-checking testbench for the timer min-heap: directed then random requests
// depends on tmh_pkg and timer_min_heap; results checked against an in-bench heap predictor
module tb_timer_min_heap;
	timeunit 1ns;
	timeprecision 1ps;
	import tmh_pkg::*;

	localparam int CAP = 32;
	localparam int IDS = 1024;
	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 60;

	typedef struct packed {
		logic [31:0] now;
		logic [23:0] tmo;
		logic [9:0]  id;
		logic [2:0]  req;
	} request_t;

	typedef struct packed {
		logic        fired;
		logic [9:0]  fired_id;
		logic [23:0] tick;
		logic [5:0]  occ;
		logic [1:0]  st;
		logic        last;
	} result_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser, m_tlast;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;

	timer_min_heap dut (.*);

	// predictor state
	logic [31:0] p_exp [CAP];
	logic [9:0]  p_own [CAP];
	int          p_slot [IDS];
	bit          p_present [IDS];
	int          p_count;

	request_t pending_reqs [$];
	result_t  expected_results [$];
	int       mismatches, watchdog_cnt;
	bit       rx_hold, stim_done;
	logic [31:0] clock_ms;
	logic [9:0]  live_ids [$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit is_later(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d != 0 && !d[31];
	endfunction

	function automatic void swap_ent(int a, int b);
		logic [31:0] e;
		logic [9:0] o;
		e = p_exp[a]; o = p_own[a];
		p_exp[a] = p_exp[b]; p_own[a] = p_own[b];
		p_exp[b] = e; p_own[b] = o;
		p_slot[p_own[a]] = a;
		p_slot[p_own[b]] = b;
	endfunction

	function automatic void bubble_up(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!is_later(p_exp[p], p_exp[i])) break;
			swap_ent(p, i);
			i = p;
		end
	endfunction

	function automatic bit bubble_down(int i, int n);
		int start, c;
		start = i;
		c = 2 * i + 1;
		while (c < n) begin
			if (c + 1 < n && is_later(p_exp[c], p_exp[c+1])) c++;
			if (!is_later(p_exp[i], p_exp[c])) break;
			swap_ent(i, c);
			i = c;
			c = 2 * i + 1;
		end
		return i > start;
	endfunction

	function automatic void drop_slot(int i);
		int n;
		n = p_count - 1;
		p_present[p_own[i]] = 0;
		p_count = n;
		if (i != n) begin
			p_exp[i] = p_exp[n];
			p_own[i] = p_own[n];
			p_slot[p_own[i]] = i;
			if (!bubble_down(i, n)) bubble_up(i);
		end
	endfunction

	function automatic logic [23:0] ms_to_next(logic [31:0] now);
		logic [31:0] d;
		if (p_count == 0) return '0;
		d = p_exp[0] - now;
		if (d == 0 || d[31]) return '0;
		return d > 32'hFFFFFF ? 24'hFFFFFF : d[23:0];
	endfunction

	function automatic void push_result(bit fired, logic [9:0] id, logic [23:0] tick,
			st_t st, bit last);
		result_t r;
		r.fired = fired; r.fired_id = id; r.tick = tick;
		r.occ = 6'(p_count); r.st = st; r.last = last;
		expected_results = {expected_results, r};
	endfunction

	// works out every result a request causes and updates the predicted heap
	function automatic void predict_request(request_t q);
		st_t st;
		int s;
		logic [9:0] who;
		st = ST_OK;
		case (q.req)
			REQ_ADD:
				if (p_present[q.id] || p_count >= CAP) st = ST_DUP;
				else begin
					s = p_count;
					p_exp[s] = q.now + q.tmo;
					p_own[s] = q.id;
					p_slot[q.id] = s;
					p_present[q.id] = 1;
					p_count++;
					bubble_up(s);
				end
			REQ_ADJ:
				if (!p_present[q.id]) st = ST_UNK;
				else begin
					s = p_slot[q.id];
					p_exp[s] = q.now + q.tmo;
					void'(bubble_down(s, p_count));
				end
			REQ_FIRE:
				if (!p_present[q.id]) st = ST_UNK;
				else begin
					drop_slot(p_slot[q.id]);
					push_result(1, q.id, '0, ST_OK, 1);
					return;
				end
			REQ_EXP:
				if (p_count == 0) st = ST_EMPTY;
				else
					while (p_count > 0 && !is_later(p_exp[0], q.now)) begin
						who = p_own[0];
						drop_slot(0);
						push_result(1, who, '0, ST_OK, 0);
					end
			REQ_POP:
				if (p_count == 0) st = ST_EMPTY;
				else drop_slot(0);
			REQ_CLR: begin
				for (int k = 0; k < IDS; k++) p_present[k] = 0;
				p_count = 0;
			end
			default: ;
		endcase
		push_result(0, '0, ms_to_next(q.now), st, 1);
	endfunction

	function automatic void queue_req(logic [2:0] req, logic [9:0] id, logic [23:0] tmo,
			logic [31:0] now);
		request_t q;
		q.req = req; q.id = id; q.tmo = tmo; q.now = now;
		pending_reqs = {pending_reqs, q};
	endfunction

	// random id, mostly one that is probably live
	function automatic logic [9:0] pick_id();
		if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
			return live_ids[$urandom_range(0, live_ids.size() - 1)];
		return 10'($urandom_range(0, 1023));
	endfunction

	// time advances mostly slowly, with occasional large jumps across the wrap
	function automatic logic [31:0] step_clock();
		case ($urandom_range(0, 9))
			0: clock_ms = clock_ms + $urandom();
			1, 2: clock_ms = clock_ms + $urandom_range(0, 2000000);
			default: clock_ms = clock_ms + $urandom_range(0, 300);
		endcase
		return clock_ms;
	endfunction

	function automatic logic [23:0] pick_tmo();
		case ($urandom_range(0, 7))
			0: return 24'hFFFFFF;
			1: return '0;
			2: return 24'($urandom_range(0, 24'hFFFFFF));
			default: return 24'($urandom_range(0, 400));
		endcase
	endfunction

	// request transaction taken at the last rising edge
	bit in_taken;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_taken <= 0;
		else in_taken <= s_tvalid && s_tready;
	end

	// driver: presents requests from the queue, idling at random
	bit drv_calm;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
		end else begin
			if (in_taken) begin
				predict_request(pending_reqs.pop_front());
			end
			if (in_taken || !s_tvalid) begin
				if (pending_reqs.size() > 0 && (drv_calm || $urandom_range(0, 99) >= 33)) begin
					s_tvalid <= 1;
					s_tdata  <= IN_W'(pending_reqs[0]);
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// receiver ready: random stalls, plus a long hold-off when requested
	bit rx_calm;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 0;
		else m_tready <= !rx_hold && (rx_calm || $urandom_range(0, 99) >= 33);
	end

	// hold the receiver off for a long stretch after reset while the driver keeps offering
	initial begin
		rx_hold = 1;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		rx_hold = 0;
	end

	// monitor: compares each result transaction with the oldest expectation
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) watchdog_cnt <= 0;
			else watchdog_cnt <= watchdog_cnt + 1;
			if (m_tvalid && m_tready) begin
				got.fired = m_tuser; got.fired_id = m_tdata[9:0];
				got.tick = m_tdata[33:10]; got.occ = m_tdata[39:34];
				got.st = m_tdata[41:40]; got.last = m_tlast;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) $display("expected %p, got %p", want, got);
					end
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (watchdog_cnt >= WATCHDOG) begin
				$display("timer_min_heap: mismatch");
				$finish;
			end
		end
	end

	int gen;
	logic [9:0] fid;
	initial begin
		arst_n = 0; mismatches = 0; watchdog_cnt = 0; p_count = 0;
		drv_calm = 0; rx_calm = 0; clock_ms = 32'h7FFF_FF00;
		for (int k = 0; k < IDS; k++) p_present[k] = 0;

		// directed: every request kind, empty and full cases, duplicates, extremes
		queue_req(REQ_EXP, 0, 0, 0);
		queue_req(REQ_POP, 0, 0, 0);
		queue_req(REQ_ADJ, 5, 1, 0);
		queue_req(REQ_FIRE, 5, 0, 0);
		queue_req(REQ_ADD, 10'h3FF, 24'hFFFFFF, 32'hFFFF_FFFF);
		queue_req(REQ_ADD, 0, 0, 32'hFFFF_FFFF);
		queue_req(REQ_ADD, 0, 7, 32'h0);
		queue_req(REQ_ADD, 10'h155, 24'h555555, 32'h5555_5555);
		queue_req(REQ_ADD, 10'h2AA, 24'hAAAAAA, 32'hAAAA_AAAA);
		queue_req(REQ_ADJ, 10'h3FF, 0, 32'h0);
		queue_req(REQ_FIRE, 10'h155, 0, 0);
		queue_req(REQ_EXP, 0, 0, 32'h0000_0010);
		queue_req(3'd6, 10'h3FF, 24'hFFFFFF, 32'hFFFF_FFFF);
		queue_req(3'd7, 0, 0, 0);
		for (int k = 0; k < 33; k++) queue_req(REQ_ADD, 10'(k * 3), 24'(k), 32'h1000);
		queue_req(REQ_POP, 0, 0, 32'h1000);
		queue_req(REQ_EXP, 0, 0, 32'h1010);
		queue_req(REQ_CLR, 0, 0, 0);
		queue_req(REQ_EXP, 0, 0, 0);

		#80 arst_n = 1;

		// random: mixed add/adjust/fire/expire/pop, with occasional clear or unknown type
		for (gen = 0; gen < 330; gen++) begin
			if (gen == 120) begin
				wait (pending_reqs.size() == 0);
				drv_calm = 1; rx_calm = 1;
			end
			if (gen == 200) begin
				wait (pending_reqs.size() == 0);
				drv_calm = 0; rx_calm = 0;
			end
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: begin
					fid = 10'($urandom_range(0, 1023));
					live_ids = {live_ids, fid};
					if (live_ids.size() > 40) void'(live_ids.pop_front());
					queue_req(REQ_ADD, fid, pick_tmo(), step_clock());
				end
				7, 8, 9: queue_req(REQ_ADJ, pick_id(), pick_tmo(), step_clock());
				10, 11, 12: queue_req(REQ_FIRE, pick_id(), pick_tmo(), step_clock());
				13, 14, 15: queue_req(REQ_EXP, pick_id(), pick_tmo(), step_clock());
				16, 17: queue_req(REQ_POP, pick_id(), pick_tmo(), step_clock());
				18: queue_req($urandom_range(0, 1) ? REQ_CLR : 3'($urandom_range(6, 7)),
						pick_id(), pick_tmo(), step_clock());
				default: queue_req(REQ_ADD, 10'($urandom_range(0, 1023)),
						24'($urandom_range(0, 24'hFFFFFF)), $urandom());
			endcase
		end

		wait (pending_reqs.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("timer_min_heap: match");
		else
			$display("timer_min_heap: mismatch");
		$finish;
	end
endmodule
